### design/glos_pkg.sv
// Shared types and constants for the grid line-of-sight checker.
// Used by the map memory, the line stepper, the top level and the checker.
package glos_pkg;

    localparam int COORD_W = 6;
    localparam int COORD_SPAN = 1 << COORD_W;

    // Item kind codes.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [COORD_W-1:0] t_coord;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    // Status of the line stepper for the sequencer.
    typedef struct packed {
        logic trivial;
        logic first;
        logic last;
    } t_step_stat;

endpackage

### design/glos_map_mem.sv
// Obstruction map: one bit per cell, one write and one registered read per cycle.
// Runs a clearing pass after reset. Depends on glos_pkg.
module glos_map_mem #(
    parameter int MAP_SIDE = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_we,
    input  glos_pkg::t_coord i_wx,
    input  glos_pkg::t_coord i_wy,
    input  logic           i_wbit,
    input  logic           i_re,
    input  glos_pkg::t_coord i_rx,
    input  glos_pkg::t_coord i_ry,
    output logic           o_rd_blocks,
    output logic           o_busy
);

    localparam int EFF = (MAP_SIDE < glos_pkg::COORD_SPAN) ? MAP_SIDE : glos_pkg::COORD_SPAN;
    localparam int DEPTH = EFF * EFF;
    localparam int AW = $clog2(DEPTH);
    localparam logic [glos_pkg::COORD_W:0] SIDE_C = (glos_pkg::COORD_W + 1)'(EFF);

    logic mem [DEPTH];

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          r_q;
    logic          r_rd_ok;

    logic          w_in_grid;
    logic          rd_in_grid;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic          we_eff;
    logic [AW-1:0] we_addr;
    logic          we_bit;

    always_comb begin
        w_in_grid  = ({1'b0, i_wx} < SIDE_C) && ({1'b0, i_wy} < SIDE_C);
        rd_in_grid = ({1'b0, i_rx} < SIDE_C) && ({1'b0, i_ry} < SIDE_C);
        waddr = AW'(i_wy) * AW'(EFF) + AW'(i_wx);
        raddr = AW'(i_ry) * AW'(EFF) + AW'(i_rx);
        if (r_clearing) begin
            we_eff  = 1'b1;
            we_addr = r_clr_addr;
            we_bit  = 1'b0;
        end else begin
            we_eff  = i_we && w_in_grid;
            we_addr = waddr;
            we_bit  = i_wbit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_eff) begin
            mem[we_addr] <= we_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_rd_ok    <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            // A read outside the grid counts as open.
            r_rd_ok <= i_re && rd_in_grid;
        end
    end

    assign o_rd_blocks = r_q && r_rd_ok;
    assign o_busy      = r_clearing;

endmodule

### design/glos_stepper.sv
// Line stepper: walks the major axis one cell per advance and tracks the rounded
// minor offset with a single shared add and compare. Depends on glos_pkg.
module glos_stepper (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic                  i_advance,
    input  glos_pkg::t_coord      i_from_x,
    input  glos_pkg::t_coord      i_from_y,
    input  glos_pkg::t_coord      i_to_x,
    input  glos_pkg::t_coord      i_to_y,
    output glos_pkg::t_coord      o_x,
    output glos_pkg::t_coord      o_y,
    output glos_pkg::t_step_stat  o_stat
);

    localparam int RW = glos_pkg::COORD_W + 2;

    glos_pkg::t_coord r_i;
    glos_pkg::t_coord r_dmaj;
    glos_pkg::t_coord r_m;
    glos_pkg::t_coord r_maj;
    glos_pkg::t_coord r_min;
    logic             r_xmaj;
    logic             r_maj_neg;
    logic             r_min_neg;
    logic [RW-1:0]    r_rem;

    glos_pkg::t_coord adx;
    glos_pkg::t_coord ady;
    logic             x_neg;
    logic             y_neg;
    logic             xmaj;
    logic [RW-1:0]    sum;
    logic [RW-1:0]    two_d;
    logic             carry;

    always_comb begin
        x_neg = i_to_x < i_from_x;
        y_neg = i_to_y < i_from_y;
        adx   = x_neg ? (i_from_x - i_to_x) : (i_to_x - i_from_x);
        ady   = y_neg ? (i_from_y - i_to_y) : (i_to_y - i_from_y);
        xmaj  = !(adx < ady);
        // The remainder holds 2*m*i + D minus 2*D times the current offset.
        sum   = r_rem + {1'b0, r_m, 1'b0};
        two_d = {1'b0, r_dmaj, 1'b0};
        carry = !(sum < two_d);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_i       <= '0;
            r_xmaj    <= xmaj;
            r_dmaj    <= xmaj ? adx : ady;
            r_m       <= xmaj ? ady : adx;
            r_maj     <= xmaj ? i_from_x : i_from_y;
            r_min     <= xmaj ? i_from_y : i_from_x;
            r_maj_neg <= xmaj ? x_neg : y_neg;
            r_min_neg <= xmaj ? y_neg : x_neg;
            r_rem     <= RW'(xmaj ? adx : ady);
        end else if (i_advance) begin
            r_i   <= r_i + glos_pkg::COORD_W'(1);
            r_maj <= r_maj_neg ? (r_maj - glos_pkg::COORD_W'(1))
                               : (r_maj + glos_pkg::COORD_W'(1));
            if (carry) begin
                r_min <= r_min_neg ? (r_min - glos_pkg::COORD_W'(1))
                                   : (r_min + glos_pkg::COORD_W'(1));
                r_rem <= sum - two_d;
            end else begin
                r_rem <= sum;
            end
        end
    end

    always_comb begin
        o_x            = r_xmaj ? r_maj : r_min;
        o_y            = r_xmaj ? r_min : r_maj;
        o_stat.trivial = r_dmaj < glos_pkg::COORD_W'(2);
        o_stat.first   = r_i == '0;
        o_stat.last    = r_i == (r_dmaj - glos_pkg::COORD_W'(1));
    end

endmodule

### design/grid_line_of_sight_check_core.sv
// Top level of the grid line-of-sight checker: sequencer, output register and
// the map memory and line stepper instances. Depends on glos_pkg, glos_map_mem, glos_stepper.

// A write item gives no result. A query item walks the cells strictly between its
// endpoints, one map read per cycle through the single read port of the map memory,
// and then offers its result; a blocking cell ends the walk early. The block takes
// no new item during the walk. Queries with endpoints equal or adjacent answer visible
// without reading the map. A finished result waits in an output register; a later
// result that finds that register still occupied waits until it is taken, and the
// input stays closed meanwhile. The map is cleared after reset by a pass over all
// min(MAP_SIDE, 64)^2 cells (4096 at the default), during which no item is taken.
module grid_line_of_sight_check_core #(
    parameter int MAP_SIDE = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_kind,
    input  glos_pkg::t_coord i_cell_x,
    input  glos_pkg::t_coord i_cell_y,
    input  logic             i_cell_blocks,
    input  glos_pkg::t_coord i_from_x,
    input  glos_pkg::t_coord i_from_y,
    input  glos_pkg::t_coord i_to_x,
    input  glos_pkg::t_coord i_to_y,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_visible
);

    glos_pkg::t_state     r_state;
    glos_pkg::t_state     n_state;
    logic                 r_chk;
    logic                 n_chk;
    logic                 r_vis;
    logic                 n_vis;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_out_vis;

    logic                 in_acc;
    logic                 do_write;
    logic                 do_load;
    logic                 issue;
    logic                 advance;
    logic                 blocked;
    logic                 out_free;
    logic                 mem_busy;
    logic                 rd_blocks;
    glos_pkg::t_coord     step_x;
    glos_pkg::t_coord     step_y;
    glos_pkg::t_step_stat stat;

    glos_map_mem #(
        .MAP_SIDE (MAP_SIDE)
    ) u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_we        (do_write),
        .i_wx        (i_cell_x),
        .i_wy        (i_cell_y),
        .i_wbit      (i_cell_blocks),
        .i_re        (issue),
        .i_rx        (step_x),
        .i_ry        (step_y),
        .o_rd_blocks (rd_blocks),
        .o_busy      (mem_busy)
    );

    glos_stepper u_step (
        .i_clk     (i_clk),
        .i_load    (do_load),
        .i_advance (advance),
        .i_from_x  (i_from_x),
        .i_from_y  (i_from_y),
        .i_to_x    (i_to_x),
        .i_to_y    (i_to_y),
        .o_x       (step_x),
        .o_y       (step_y),
        .o_stat    (stat)
    );

    always_comb begin
        o_in_ready = r_state == glos_pkg::ST_IDLE;
        in_acc     = i_in_valid && o_in_ready;
        do_write   = in_acc && (i_kind == glos_pkg::KIND_WRITE);
        do_load    = in_acc && (i_kind == glos_pkg::KIND_QUERY);
        blocked    = r_chk && rd_blocks;
        out_free   = !r_out_valid || i_out_ready;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            glos_pkg::ST_INIT: begin
                if (!mem_busy) begin
                    n_state = glos_pkg::ST_IDLE;
                end
            end
            glos_pkg::ST_IDLE: begin
                if (do_load) begin
                    n_state = glos_pkg::ST_WALK;
                end
            end
            glos_pkg::ST_WALK: begin
                if (stat.trivial || blocked) begin
                    n_state = glos_pkg::ST_RESULT;
                end else if (stat.last) begin
                    n_state = glos_pkg::ST_DRAIN;
                end
            end
            glos_pkg::ST_DRAIN: begin
                n_state = glos_pkg::ST_RESULT;
            end
            glos_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_state = glos_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = glos_pkg::ST_INIT;
            end
        endcase
    end

    // Sequencer outputs. Step 0 is the observer cell and is never read; the read
    // for step i is checked in the next cycle while step i+1 is issued.
    always_comb begin
        issue       = 1'b0;
        advance     = 1'b0;
        n_vis       = r_vis;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            glos_pkg::ST_WALK: begin
                issue   = !stat.trivial && !stat.first;
                advance = !stat.trivial && !stat.last;
                if (stat.trivial) begin
                    n_vis = 1'b1;
                end else if (blocked) begin
                    n_vis = 1'b0;
                end
            end
            glos_pkg::ST_DRAIN: begin
                n_vis = !blocked;
            end
            glos_pkg::ST_RESULT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                issue = 1'b0;
            end
        endcase
        n_chk = issue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= glos_pkg::ST_INIT;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vis <= n_vis;
        if (r_state == glos_pkg::ST_RESULT && out_free) begin
            r_out_vis <= r_vis;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_visible   = r_out_vis;

endmodule

### design/glos_checker.sv
// Port-level checker for the grid line-of-sight checker, bound to the top level.
// Depends on glos_pkg.
module glos_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             i_kind,
    input glos_pkg::t_coord i_cell_x,
    input glos_pkg::t_coord i_cell_y,
    input logic             i_cell_blocks,
    input glos_pkg::t_coord i_from_x,
    input glos_pkg::t_coord i_from_y,
    input glos_pkg::t_coord i_to_x,
    input glos_pkg::t_coord i_to_y,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic             o_visible
);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // A result item stays offered until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_visible))
        else $error("result item changed while stalled");

    // A query keeps the block busy for at least the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_kind == glos_pkg::KIND_QUERY |=> !o_in_ready)
        else $error("item taken right after a query");

    // A write item never raises a result.
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && in_acc && i_kind == glos_pkg::KIND_WRITE |=> !o_out_valid)
        else $error("result item after a write item");

    // The map clearing pass keeps the input closed right after reset.
    a_reset_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("item taken during map clearing");

endmodule

bind grid_line_of_sight_check_core glos_checker u_glos_checker (.*);

### sim/tb_grid_line_of_sight_check_core.sv
// Self-checking testbench for grid_line_of_sight_check_core: map writes and sight queries
// under random idling on both channels, checked against a scoreboard that models the map.
// Depends on glos_pkg and the RTL of the checker.
module tb_grid_line_of_sight_check_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 80;

    typedef struct packed {
        logic             kind;
        glos_pkg::t_coord cell_x;
        glos_pkg::t_coord cell_y;
        logic             cell_blocks;
        glos_pkg::t_coord from_x;
        glos_pkg::t_coord from_y;
        glos_pkg::t_coord to_x;
        glos_pkg::t_coord to_y;
    } t_item;

    // Keeps its own copy of the obstruction map and the visibility answers still owed.
    class t_sight_board;
        localparam int SIDE = glos_pkg::COORD_SPAN;

        bit blocked [SIDE*SIDE];
        bit visible_due [$];
        int fails;

        function new();
            foreach (blocked[k]) blocked[k] = 1'b0;
            fails = 0;
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            fails++;
        endtask

        function int pending();
            return visible_due.size();
        endfunction

        function bit blocks_at(int x, int y);
            if (x < 0 || y < 0 || x >= SIDE || y >= SIDE) return 1'b0;
            return blocked[y*SIDE + x];
        endfunction

        // Rounded delta * i / d with halves away from zero; d is positive.
        function int rounded_offset(int delta, int i, int d);
            int mag;
            int q;
            mag = (delta < 0) ? -delta : delta;
            q = (2*mag*i + d) / (2*d);
            return (delta < 0) ? -q : q;
        endfunction

        function bit sight_clear(int x0, int y0, int x1, int y1);
            int dx;
            int dy;
            int adx;
            int ady;
            int dir;
            dx = x1 - x0;
            dy = y1 - y0;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            if (adx < ady) begin
                dir = (dy < 0) ? -1 : 1;
                for (int i = 1; i < ady; i++)
                    if (blocks_at(x0 + rounded_offset(dx, i, ady), y0 + dir*i)) return 1'b0;
            end else begin
                dir = (dx < 0) ? -1 : 1;
                for (int i = 1; i < adx; i++)
                    if (blocks_at(x0 + dir*i, y0 + rounded_offset(dy, i, adx))) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_item(t_item it);
            if (it.kind == glos_pkg::KIND_WRITE) begin
                if (it.cell_x < SIDE && it.cell_y < SIDE)
                    blocked[it.cell_y*SIDE + it.cell_x] = it.cell_blocks;
            end else begin
                visible_due.push_back(sight_clear(it.from_x, it.from_y, it.to_x, it.to_y));
            end
        endfunction

        task check_result(logic visible);
            bit want;
            if (visible_due.size() == 0) begin
                report($sformatf("result visible=%0b with no query outstanding", visible));
            end else begin
                want = visible_due.pop_front();
                if (visible !== want)
                    report($sformatf("visible got %0b want %0b", visible, want));
            end
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic             i_kind = glos_pkg::KIND_WRITE;
    glos_pkg::t_coord i_cell_x = '0;
    glos_pkg::t_coord i_cell_y = '0;
    logic             i_cell_blocks = 1'b0;
    glos_pkg::t_coord i_from_x = '0;
    glos_pkg::t_coord i_from_y = '0;
    glos_pkg::t_coord i_to_x = '0;
    glos_pkg::t_coord i_to_y = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic             o_visible;

    t_sight_board board = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold = 0;
    int cycles = 0;

    grid_line_of_sight_check_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_cell_blocks(i_cell_blocks),
        .i_from_x     (i_from_x),
        .i_from_y     (i_from_y),
        .i_to_x       (i_to_x),
        .i_to_y       (i_to_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_visible    (o_visible)
    );

    always #6 i_clk = ~i_clk;

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task send_item(t_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_kind = it.kind;
        i_cell_x = it.cell_x;
        i_cell_y = it.cell_y;
        i_cell_blocks = it.cell_blocks;
        i_from_x = it.from_x;
        i_from_y = it.from_y;
        i_to_x = it.to_x;
        i_to_y = it.to_y;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_item(it);
        @(negedge i_clk);
    endtask

    function automatic t_item noise_item();
        t_item it;
        it = t_item'({$urandom, $urandom});
        return it;
    endfunction

    task write_cell(int x, int y, bit b);
        t_item it;
        it = noise_item();
        it.kind = glos_pkg::KIND_WRITE;
        it.cell_x = glos_pkg::t_coord'(x);
        it.cell_y = glos_pkg::t_coord'(y);
        it.cell_blocks = b;
        send_item(it);
    endtask

    task query_sight(int fx, int fy, int tx, int ty);
        t_item it;
        it = noise_item();
        it.kind = glos_pkg::KIND_QUERY;
        it.from_x = glos_pkg::t_coord'(fx);
        it.from_y = glos_pkg::t_coord'(fy);
        it.to_x = glos_pkg::t_coord'(tx);
        it.to_y = glos_pkg::t_coord'(ty);
        send_item(it);
    endtask

    task wait_results_done();
        i_in_valid = 1'b0;
        do @(negedge i_clk); while (board.pending() != 0);
    endtask

    // Most items land in a 16x16 window so that walls are dense enough to hide targets.
    task run_phase(int count, int s_idle, int r_idle);
        t_item it;
        int wx;
        int wy;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        wx = $urandom_range(0, glos_pkg::COORD_SPAN - 16);
        wy = $urandom_range(0, glos_pkg::COORD_SPAN - 16);
        repeat (count) begin
            it = noise_item();
            it.kind = ($urandom_range(0, 99) < 55) ? glos_pkg::KIND_WRITE : glos_pkg::KIND_QUERY;
            if ($urandom_range(0, 4) != 0) begin
                it.cell_x = glos_pkg::t_coord'(wx + $urandom_range(0, 15));
                it.cell_y = glos_pkg::t_coord'(wy + $urandom_range(0, 15));
                it.cell_blocks = ($urandom_range(0, 99) < 30);
                it.from_x = glos_pkg::t_coord'(wx + $urandom_range(0, 15));
                it.from_y = glos_pkg::t_coord'(wy + $urandom_range(0, 15));
                it.to_x = glos_pkg::t_coord'(wx + $urandom_range(0, 15));
                it.to_y = glos_pkg::t_coord'(wy + $urandom_range(0, 15));
            end
            send_item(it);
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (recv_hold > 0) begin
                i_out_ready = 1'b0;
                recv_hold--;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) board.check_result(o_visible);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Endpoints equal, adjacent and at the corners of an empty map.
        query_sight(0, 0, 0, 0);
        query_sight(63, 63, 63, 63);
        query_sight(5, 5, 6, 6);
        query_sight(0, 0, 63, 63);
        // Blocked endpoints are never tested.
        write_cell(0, 0, 1);
        write_cell(63, 63, 1);
        query_sight(0, 0, 63, 63);
        query_sight(63, 63, 0, 0);
        query_sight(0, 0, 0, 0);
        write_cell(31, 31, 1);
        query_sight(0, 0, 63, 63);
        query_sight(63, 0, 0, 63);
        // Half steps round away from zero on both signs and on either major axis.
        write_cell(1, 1, 1);
        query_sight(0, 0, 4, 2);
        query_sight(0, 2, 4, 0);
        query_sight(2, 0, 0, 4);
        write_cell(1, 1, 0);
        query_sight(0, 0, 4, 2);
        query_sight(10, 0, 11, 63);
        write_cell(11, 32, 1);
        query_sight(10, 0, 11, 63);
        write_cell(11, 32, 0);
        write_cell(31, 31, 0);
        wait_results_done();

        // Long receiver stall while items keep coming, so the input backs up.
        recv_hold = 400;
        run_phase(500, 9, 76);
        wait_results_done();
        run_phase(500, 76, 9);
        wait_results_done();
        run_phase(500, 0, 0);
        wait_results_done();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (board.pending() != 0)
            board.report($sformatf("%0d results never arrived", board.pending()));
        if (board.fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
design/glos_pkg.sv
design/glos_map_mem.sv
design/glos_stepper.sv
design/grid_line_of_sight_check_core.sv
design/glos_checker.sv
sim/tb_grid_line_of_sight_check_core.sv
